### rtl/core/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared constants, codes and types of the toroidal life generation engine.
// ----------------------------------------------------------------------------
package tlg_pkg;

  // Board storage
  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned LaneW     = $clog2(MaxWidth);
  localparam int unsigned RowIdxW   = $clog2(MaxHeight);
  localparam int unsigned WUseW     = $clog2(MaxWidth + 1);
  localparam int unsigned HUseW     = $clog2(MaxHeight + 1);

  // Field widths
  localparam int unsigned ModeW = 2;
  localparam int unsigned ColW  = 6;
  localparam int unsigned RowW  = 6;
  localparam int unsigned SizeW = 7;
  localparam int unsigned GenW  = 64;

  // Rule B3/S23
  localparam int unsigned BirthCount = 3;
  localparam int unsigned SurviveLow = 2;

  // Request modes
  localparam logic [ModeW-1:0] ModeWrite = 2'd0;
  localparam logic [ModeW-1:0] ModeRead  = 2'd1;
  localparam logic [ModeW-1:0] ModeStep  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             cell_value;
  } req_t;

  typedef struct packed {
    logic            read_value;
    logic            any_alive;
    logic [GenW-1:0] generation;
    logic            extinct;
  } rsp_t;

  // Per-cell control of the row ring
  typedef struct packed {
    logic shift;  // advance the ring by one row
    logic tail;   // this cell closes the ring and takes the head's output
  } cell_ctl_t;

endpackage

### rtl/core/tlg_req_if.sv
// ----------------------------------------------------------------------------
// tlg_req_if
// Valid/ready request channel carrying one board operation.
// ----------------------------------------------------------------------------
interface tlg_req_if;
  import tlg_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tlg_rsp_if.sv
// ----------------------------------------------------------------------------
// tlg_rsp_if
// Valid/ready result channel carrying the board status after one request.
// ----------------------------------------------------------------------------
interface tlg_rsp_if;
  import tlg_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tlg_row_cell.sv
// ----------------------------------------------------------------------------
// tlg_row_cell
// One board row of the ring: holds the row and hands it to its neighbor.
// ----------------------------------------------------------------------------
module tlg_row_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlg_pkg::cell_ctl_t           ctl_i,
  input  logic [tlg_pkg::MaxWidth-1:0] next_row_i,
  input  logic [tlg_pkg::MaxWidth-1:0] head_row_i,
  output logic [tlg_pkg::MaxWidth-1:0] row_o
);
  import tlg_pkg::*;

  logic [MaxWidth-1:0] row_q;

  // Take the neighbor's row, or the head's result when closing the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (ctl_i.shift) begin
      row_q <= ctl_i.tail ? head_row_i : next_row_i;
    end
  end

  assign row_o = row_q;

endmodule

### rtl/core/tlg_row_rule.sv
// ----------------------------------------------------------------------------
// tlg_row_rule
// Next-generation value of one row from its upper, own and lower rows.
// ----------------------------------------------------------------------------
module tlg_row_rule (
  input  logic [tlg_pkg::MaxWidth-1:0] up_i,
  input  logic [tlg_pkg::MaxWidth-1:0] cur_i,
  input  logic [tlg_pkg::MaxWidth-1:0] dn_i,
  input  logic [tlg_pkg::WUseW-1:0]    w_i,
  input  logic                         apply_i,
  output logic [tlg_pkg::MaxWidth-1:0] nxt_o,
  output logic                         live_o
);
  import tlg_pkg::*;

  localparam int unsigned CntW = 4;

  logic [LaneW-1:0]    wlast;
  logic [MaxWidth-1:0] mask;

  assign wlast = LaneW'(w_i - WUseW'(1));

  for (genvar c = 0; c < MaxWidth; c++) begin : g_lane
    localparam int unsigned Rc = (c + 1) % MaxWidth;
    logic            l_up, l_cur, l_dn;
    logic            r_up, r_cur, r_dn;
    logic            at_edge;
    logic [CntW-1:0] n;
    logic            alive;

    // Wrap left of column zero onto the last column in use
    if (c == 0) begin : g_first
      assign l_up  = up_i[wlast];
      assign l_cur = cur_i[wlast];
      assign l_dn  = dn_i[wlast];
    end else begin : g_mid
      assign l_up  = up_i[c-1];
      assign l_cur = cur_i[c-1];
      assign l_dn  = dn_i[c-1];
    end

    // Wrap right of the last column in use onto column zero
    assign at_edge = (wlast == LaneW'(c));
    assign r_up    = at_edge ? up_i[0]  : up_i[Rc];
    assign r_cur   = at_edge ? cur_i[0] : cur_i[Rc];
    assign r_dn    = at_edge ? dn_i[0]  : dn_i[Rc];

    assign n = CntW'(l_up) + CntW'(up_i[c]) + CntW'(r_up)
             + CntW'(l_cur) + CntW'(r_cur)
             + CntW'(l_dn) + CntW'(dn_i[c]) + CntW'(r_dn);

    assign alive = cur_i[c] ? ((n == CntW'(SurviveLow)) || (n == CntW'(BirthCount)))
                            : (n == CntW'(BirthCount));

    assign mask[c]  = (WUseW'(c) < w_i);
    assign nxt_o[c] = (apply_i && mask[c]) ? alive : cur_i[c];
  end

  assign live_o = |(nxt_o & mask);

endmodule

### rtl/core/toroidal_life_generation_engine_top.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine_top
// Conway life (B3/S23) on a wrapping board held in a ring of row cells.
// ----------------------------------------------------------------------------
// The board is a chain of MaxHeight row cells; the first height_in_use of
// them form a ring that passes one row per cycle through a single head
// (cell zero), where the rule unit, the cell write and the cell read sit.
// Every request, whatever its mode, takes two laps of the ring: the first
// lap applies a write or captures a read and saves the last row in use, the
// second lap computes the new rows for a generation step (or passes them
// through for other modes) and gathers whether any cell in the used area is
// alive. The next request is taken as soon as the result has been moved
// to the output register, even if that result has not yet been taken.
// Rows beyond the area in use never move. Columns wrap at the clamped
// width; size values of 0 act as 1 and values above the maximum act as
// the maximum. Reset clears the board, sets the generation count to 1 and
// clears the extinct flag at once; there is no clearing pass.
// Configuration must be written only while idle.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlg_pkg::SizeW-1:0]   cfg_wdata_i,
  tlg_req_if.sink                     req_i,
  tlg_rsp_if.source                   rsp_o
);
  import tlg_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StDone
  } state_e;

  // Control state
  state_e               state_q;
  logic [RowIdxW-1:0]   t_q;
  logic                 lap_q;
  logic                 out_valid_q;
  logic [GenW-1:0]      gen_q;
  logic                 ext_q;
  logic [SizeW-1:0]     width_q;
  logic [SizeW-1:0]     height_q;

  // Payload
  req_t                 req_q;
  logic                 rd_q;
  logic                 alive_q;
  logic [MaxWidth-1:0]  prev_q;
  logic [MaxWidth-1:0]  row0_q;
  logic [MaxWidth-1:0]  last_q;
  rsp_t                 rsp_q;

  // Ring
  logic [MaxWidth-1:0]  rows [MaxHeight];
  cell_ctl_t            cell_ctl [MaxHeight];

  logic [WUseW-1:0]     w_use;
  logic [HUseW-1:0]     h_use;
  logic [RowIdxW-1:0]   h_last;
  logic [LaneW-1:0]     col_idx;
  logic                 req_fire;
  logic                 rsp_load;
  logic                 sweeping;
  logic                 t_first;
  logic                 t_last;
  logic                 col_in;
  logic                 row_hit;
  logic                 wr_hit;
  logic                 rd_hit;
  logic                 adv;
  logic [MaxWidth-1:0]  cur;
  logic [MaxWidth-1:0]  up_row;
  logic [MaxWidth-1:0]  dn_row;
  logic [MaxWidth-1:0]  head_wr;
  logic [MaxWidth-1:0]  rule_nxt;
  logic                 rule_live;
  logic [MaxWidth-1:0]  head_new;
  logic                 alive_fin;

  // Clamp the size registers into the board
  always_comb begin
    if (width_q == '0) begin
      w_use = WUseW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_use = WUseW'(MaxWidth);
    end else begin
      w_use = WUseW'(width_q);
    end
    if (height_q == '0) begin
      h_use = HUseW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      h_use = HUseW'(MaxHeight);
    end else begin
      h_use = HUseW'(height_q);
    end
  end

  assign h_last   = RowIdxW'(h_use - HUseW'(1));
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == StDone) && (!out_valid_q || rsp_o.ready);
  assign sweeping = (state_q == StSweep);
  assign t_first  = (t_q == '0);
  assign t_last   = (t_q == h_last);
  assign adv      = (req_q.mode == ModeStep);

  // Head of the ring: cell access on the first lap
  assign col_idx = LaneW'(req_q.col);
  assign col_in  = (32'(req_q.col) < 32'(w_use));
  assign row_hit = (32'(t_q) == 32'(req_q.row));
  assign wr_hit  = !lap_q && row_hit && col_in && (req_q.mode == ModeWrite);
  assign rd_hit  = !lap_q && row_hit && col_in && (req_q.mode == ModeRead);

  assign cur = rows[0];

  always_comb begin
    head_wr          = cur;
    head_wr[col_idx] = req_q.cell_value;
  end

  // Neighbor rows on the second lap: the saved last row above row zero,
  // the saved old row zero below the last row, otherwise the ring itself
  assign up_row = t_first ? last_q : prev_q;

  always_comb begin
    if (t_last) begin
      dn_row = t_first ? cur : row0_q;
    end else begin
      dn_row = rows[1];
    end
  end

  tlg_row_rule u_rule (
    .up_i    (up_row),
    .cur_i   (cur),
    .dn_i    (dn_row),
    .w_i     (w_use),
    .apply_i (lap_q && adv),
    .nxt_o   (rule_nxt),
    .live_o  (rule_live)
  );

  assign head_new  = lap_q ? rule_nxt : (wr_hit ? head_wr : cur);
  assign alive_fin = alive_q | rule_live;

  // Row cells: only the rows in use rotate; the last one closes the ring
  for (genvar k = 0; k < MaxHeight; k++) begin : g_cell
    logic [MaxWidth-1:0] nb_row;

    if (k == MaxHeight - 1) begin : g_end
      assign nb_row = head_new;
    end else begin : g_link
      assign nb_row = rows[k+1];
    end

    assign cell_ctl[k].shift = sweeping && (HUseW'(k) < h_use);
    assign cell_ctl[k].tail  = (h_last == RowIdxW'(k));

    tlg_row_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cell_ctl[k]),
      .next_row_i (nb_row),
      .head_row_i (head_new),
      .row_o      (rows[k])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(10);
      height_q <= SizeW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_wdata_i;
        CfgHeight: height_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // Sequencer, generation count, extinct flag and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      t_q         <= '0;
      lap_q       <= 1'b0;
      out_valid_q <= 1'b0;
      gen_q       <= GenW'(1);
      ext_q       <= 1'b0;
    end else begin
      // Drop valid once taken, unless a new result moves in at the same edge
      if (out_valid_q && rsp_o.ready && !rsp_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_fire) begin
            state_q <= StSweep;
            t_q     <= '0;
            lap_q   <= 1'b0;
          end
        end
        StSweep: begin
          if (t_last) begin
            t_q <= '0;
            if (lap_q) begin
              state_q <= StDone;
              // Count surviving generations; an empty board sticks extinct
              if (adv) begin
                if (alive_fin) begin
                  if (gen_q != '1) begin
                    gen_q <= gen_q + GenW'(1);
                  end
                end else begin
                  ext_q <= 1'b1;
                end
              end
            end else begin
              lap_q <= 1'b1;
            end
          end else begin
            t_q <= t_q + RowIdxW'(1);
          end
        end
        StDone: begin
          if (rsp_load) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Request, saved rows and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q   <= req_i.data;
      rd_q    <= 1'b0;
      alive_q <= 1'b0;
    end
    if (sweeping) begin
      prev_q <= cur;
      if (rd_hit) begin
        rd_q <= cur[col_idx];
      end
      if (!lap_q && t_last) begin
        last_q <= head_new;
      end
      if (lap_q && t_first) begin
        row0_q <= cur;
      end
      if (lap_q) begin
        alive_q <= alive_fin;
      end
    end
    if (rsp_load) begin
      rsp_q.read_value <= rd_q;
      rsp_q.any_alive  <= alive_q;
      rsp_q.generation <= gen_q;
      rsp_q.extinct    <= ext_q;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = rsp_q;

  // A taken request starts the first lap at the head row
  a_sweep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == StSweep) && (t_q == '0) && !lap_q)
    else $error("sweep did not start at row zero of the first lap");

  // Once extinct, always extinct
  a_extinct_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_q |=> ext_q)
    else $error("extinct flag cleared");

  // Only a generation step may touch the count or the flag
  a_step_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweeping && lap_q && t_last && !adv |=> $stable(gen_q) && $stable(ext_q))
    else $error("count or flag changed outside a generation step");

  // A result appears only when a finished request is moved out
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result valid without a finished request");

endmodule
